/* src/gdd_pkg.sv */
// shared constants, types and calendar tables for the date difference core
package gdd_pkg;

  localparam int unsigned YEAR_LIMIT = 9999;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;

  localparam int unsigned IN_W      = 2 * (DAY_W + MONTH_W + YEAR_W);
  localparam int unsigned IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((DIFF_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 2;

  // year shifted by 400 and moved to a march-based year
  localparam int unsigned YY_W = YEAR_W + 1;
  // quotient by 100 through a reciprocal: exact for values below 2**YY_W
  localparam int unsigned DIV100_MUL = 20972;
  localparam int unsigned DIV100_SH  = 21;
  localparam int unsigned MUL_W      = 15;
  localparam int unsigned PROD_W     = YY_W + MUL_W;
  localparam int unsigned Q_W        = PROD_W - DIV100_SH;

  localparam int unsigned DSUM_W = 9;
  localparam int unsigned B_W    = YY_W - 2;
  localparam int unsigned DN_W   = 24;
  localparam int unsigned SDIFF_W = DN_W + 1;

  localparam int signed DIFF_MAX = (1 << (DIFF_W - 1)) - 1;
  localparam int signed DIFF_MIN = -(1 << (DIFF_W - 1));

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // length of a month, february follows the leap flag
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = DAY_W'(0);
    endcase
    return len;
  endfunction

  // days before the first of the month, counted from march 1
  function automatic logic [DSUM_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DSUM_W-1:0] ofs;
    unique case (m)
      4'd3:    ofs = DSUM_W'(0);
      4'd4:    ofs = DSUM_W'(31);
      4'd5:    ofs = DSUM_W'(61);
      4'd6:    ofs = DSUM_W'(92);
      4'd7:    ofs = DSUM_W'(122);
      4'd8:    ofs = DSUM_W'(153);
      4'd9:    ofs = DSUM_W'(184);
      4'd10:   ofs = DSUM_W'(214);
      4'd11:   ofs = DSUM_W'(245);
      4'd12:   ofs = DSUM_W'(275);
      4'd1:    ofs = DSUM_W'(306);
      4'd2:    ofs = DSUM_W'(337);
      default: ofs = DSUM_W'(0);
    endcase
    return ofs;
  endfunction

endpackage

/* src/gdd_date_path.sv */
// three-stage check and day count for one calendar date
module gdd_date_path (
  input  logic                      clk_i,
  input  gdd_pkg::pipe_en_t         en_i,
  input  logic [gdd_pkg::DAY_W-1:0]   day_i,
  input  logic [gdd_pkg::MONTH_W-1:0] month_i,
  input  logic [gdd_pkg::YEAR_W-1:0]  year_i,
  output logic                      ok_o,
  output logic [gdd_pkg::DN_W-1:0]  day_num_o
);
  import gdd_pkg::*;

  // stage 1: range checks, shifted year and both quotients by 100
  logic              pre_ok;
  logic              early;
  logic [YY_W-1:0]   yy;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] prod_yy;
  logic [DSUM_W-1:0] dsum;

  logic               pre_ok_q;
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic [Q_W-1:0]     q_y_q;
  logic [YY_W-1:0]    yy_q;
  logic [Q_W-1:0]     q_yy_q;
  logic [DSUM_W-1:0]  dsum_q;

  always_comb begin
    pre_ok = (month_i >= MONTH_JAN) && (month_i <= MONTH_DEC) &&
             (32'(year_i) <= 32'(YEAR_LIMIT)) && (day_i != '0);
    early   = (month_i <= MONTH_FEB);
    yy      = YY_W'(year_i) + YY_W'(400) - YY_W'(early);
    prod_y  = PROD_W'(year_i) * PROD_W'(DIV100_MUL);
    prod_yy = PROD_W'(yy) * PROD_W'(DIV100_MUL);
    dsum    = month_offset(month_i) + DSUM_W'(day_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pre_ok_q <= pre_ok;
      day_q    <= day_i;
      month_q  <= month_i;
      year_q   <= year_i;
      q_y_q    <= prod_y[DIV100_SH +: Q_W];
      yy_q     <= yy;
      q_yy_q   <= prod_yy[DIV100_SH +: Q_W];
      dsum_q   <= dsum;
    end
  end

  // stage 2: leap rule, month length, partial day counts
  logic            cent;
  logic            leap;
  logic            ok;
  logic [DN_W-1:0] part_a;
  logic [B_W-1:0]  part_b;

  logic            ok2_q;
  logic [DN_W-1:0] part_a_q;
  logic [B_W-1:0]  part_b_q;

  always_comb begin
    cent   = (16'(year_q) == 16'(q_y_q) * 16'(100));
    leap   = (year_q[1:0] == 2'b00) && !(cent && (q_y_q[1:0] != 2'b00));
    ok     = pre_ok_q && (day_q <= month_days(month_q, leap));
    part_a = DN_W'(yy_q) * DN_W'(365) + DN_W'(dsum_q);
    part_b = B_W'(yy_q >> 2) - B_W'(q_yy_q) + B_W'(q_yy_q >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ok2_q    <= ok;
      part_a_q <= part_a;
      part_b_q <= part_b;
    end
  end

  // stage 3: full day number
  logic            ok3_q;
  logic [DN_W-1:0] dn_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      ok3_q <= ok2_q;
      dn_q  <= part_a_q + DN_W'(part_b_q);
    end
  end

  assign ok_o      = ok3_q;
  assign day_num_o = dn_q;

endmodule

/* src/gregorian_date_difference_core.sv */
// top level: date pair in, signed day difference and validity flags out
// Takes one date pair per cycle unless stalled and returns one word per pair, in order:
// three stages per date (range checks with the century quotient, leap rule
// and partial day counts, day number) and one stage that subtracts,
// saturates and holds the output word. Back-pressure stalls the whole
// pipeline; a new pair is still taken while the output word waits as long
// as an earlier stage holds a bubble. No reset-time sweep.
module gregorian_date_difference_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // first_day, first_month, first_year, second_day, second_month, second_year
  input  logic [gdd_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // day_difference
  output logic [gdd_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // first_ok, second_ok
  output logic [gdd_pkg::OUT_USER_W-1:0]      m_axis_tuser_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i
);
  import gdd_pkg::*;

  localparam int unsigned D1_LO = 0;
  localparam int unsigned M1_LO = D1_LO + DAY_W;
  localparam int unsigned Y1_LO = M1_LO + MONTH_W;
  localparam int unsigned D2_LO = Y1_LO + YEAR_W;
  localparam int unsigned M2_LO = D2_LO + DAY_W;
  localparam int unsigned Y2_LO = M2_LO + MONTH_W;

  logic     v1_q, v2_q, v3_q, v4_q;
  logic     en1, en2, en3, en4;
  pipe_en_t pen;

  always_comb begin
    en4    = !v4_q || m_axis_tready_i;
    en3    = !v3_q || en4;
    en2    = !v2_q || en3;
    en1    = !v1_q || en2;
    pen.s1 = en1 && s_axis_tvalid_i;
    pen.s2 = en2 && v1_q;
    pen.s3 = en3 && v2_q;
  end

  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  logic            ok1, ok2;
  logic [DN_W-1:0] dn1, dn2;

  gdd_date_path u_first (
    .clk_i     (clk_i),
    .en_i      (pen),
    .day_i     (s_axis_tdata_i[D1_LO +: DAY_W]),
    .month_i   (s_axis_tdata_i[M1_LO +: MONTH_W]),
    .year_i    (s_axis_tdata_i[Y1_LO +: YEAR_W]),
    .ok_o      (ok1),
    .day_num_o (dn1)
  );

  gdd_date_path u_second (
    .clk_i     (clk_i),
    .en_i      (pen),
    .day_i     (s_axis_tdata_i[D2_LO +: DAY_W]),
    .month_i   (s_axis_tdata_i[M2_LO +: MONTH_W]),
    .year_i    (s_axis_tdata_i[Y2_LO +: YEAR_W]),
    .ok_o      (ok2),
    .day_num_o (dn2)
  );

  // stage 4: difference, saturation, output word
  logic signed [SDIFF_W-1:0] sdiff;
  logic        [DIFF_W-1:0]  diff;
  logic        [DIFF_W-1:0]  diff_q;
  logic                      ok1_q, ok2_q;

  always_comb begin
    sdiff = $signed({1'b0, dn2}) - $signed({1'b0, dn1});
    if (!(ok1 && ok2)) begin
      diff = '0;
    end else if (sdiff > SDIFF_W'(DIFF_MAX)) begin
      diff = DIFF_W'(DIFF_MAX);
    end else if (sdiff < SDIFF_W'(DIFF_MIN)) begin
      diff = DIFF_W'(DIFF_MIN);
    end else begin
      diff = sdiff[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      diff_q <= diff;
      ok1_q  <= ok1;
      ok2_q  <= ok2;
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(diff_q);
  assign m_axis_tuser_o  = {ok2_q, ok1_q};

endmodule
